// File: hw/rtl/spq_pkg.sv
// ----------------------------------------------------------------------------
// spq_pkg
// Shared types and constants for the sorted priority queue and its cells.
// ----------------------------------------------------------------------------
package spq_pkg;

    localparam int TAG_BITS = 16;

    localparam logic KEY_CPU     = 1'b0;
    localparam logic KEY_ARRIVAL = 1'b1;

    typedef enum logic [1:0] {
        CMD_ENQUEUE = 2'd0,
        CMD_DEQUEUE = 2'd1,
        CMD_PEEK    = 2'd2,
        CMD_NOP     = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_WAVE,
        ST_POST
    } state_t;

    // Broadcast from the controller to every cell
    typedef struct packed {
        logic shift;
        logic order_mode;
    } cell_ctrl_t;

endpackage

// File: hw/rtl/spq_cell.sv
// ----------------------------------------------------------------------------
// spq_cell
// One slot of the queue. Holds an entry and a pass stage that hands the
// insertion wave (new or displaced entry) to the next cell.
// ----------------------------------------------------------------------------
module spq_cell #(
    parameter int INDEX     = 0,
    parameter int TIME_BITS = 16,
    parameter int CNT_W     = 7
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  spq_pkg::cell_ctrl_t                  ctrl,
    input  logic [CNT_W-1:0]                     count,
    input  logic                                 pass_valid_i,
    input  logic                                 pass_placed_i,
    input  logic [spq_pkg::TAG_BITS+2*TIME_BITS-1:0] pass_entry_i,
    input  logic [spq_pkg::TAG_BITS+2*TIME_BITS-1:0] shift_entry_i,
    output logic [spq_pkg::TAG_BITS+2*TIME_BITS-1:0] entry_o,
    output logic                                 pass_valid_o,
    output logic                                 pass_placed_o,
    output logic [spq_pkg::TAG_BITS+2*TIME_BITS-1:0] pass_entry_o
);
    import spq_pkg::*;

    localparam int ENT_W = TAG_BITS + 2 * TIME_BITS;

    logic [ENT_W-1:0]     entry_reg, entry_next;
    logic                 pass_valid_reg, pass_valid_next;
    logic                 pass_placed_reg, pass_placed_next;
    logic [ENT_W-1:0]     pass_entry_reg, pass_entry_next;
    logic [TIME_BITS-1:0] own_key, new_key;
    logic                 occupied, terminal, hit;

    assign own_key  = (ctrl.order_mode == KEY_ARRIVAL) ? entry_reg[TIME_BITS-1:0]
                                                       : entry_reg[2*TIME_BITS-1 -: TIME_BITS];
    assign new_key  = (ctrl.order_mode == KEY_ARRIVAL) ? pass_entry_i[TIME_BITS-1:0]
                                                       : pass_entry_i[2*TIME_BITS-1 -: TIME_BITS];
    assign occupied = count > CNT_W'(INDEX);
    assign terminal = count == CNT_W'(INDEX);

    // The front only yields to a strictly smaller key; later slots on ties
    generate
        if (INDEX == 0) begin : g_front
            assign hit = new_key < own_key;
        end else begin : g_rest
            assign hit = new_key <= own_key;
        end
    endgenerate

    always_comb begin
        entry_next       = entry_reg;
        pass_valid_next  = 1'b0;
        pass_placed_next = pass_placed_reg;
        pass_entry_next  = pass_entry_reg;
        if (ctrl.shift) begin
            entry_next = shift_entry_i;
        end else if (pass_valid_i) begin
            if (pass_placed_i || terminal || (occupied && hit)) begin
                entry_next = pass_entry_i;
                if (occupied) begin
                    pass_valid_next  = 1'b1;
                    pass_placed_next = 1'b1;
                    pass_entry_next  = entry_reg;
                end
            end else if (occupied) begin
                pass_valid_next  = 1'b1;
                pass_placed_next = 1'b0;
                pass_entry_next  = pass_entry_i;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pass_valid_reg <= 1'b0;
        end else begin
            pass_valid_reg <= pass_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        entry_reg       <= entry_next;
        pass_placed_reg <= pass_placed_next;
        pass_entry_reg  <= pass_entry_next;
    end

    assign entry_o       = entry_reg;
    assign pass_valid_o  = pass_valid_reg;
    assign pass_placed_o = pass_placed_reg;
    assign pass_entry_o  = pass_entry_reg;

endmodule

// File: hw/rtl/sorted_priority_queue.sv
// ----------------------------------------------------------------------------
// sorted_priority_queue
// Ready queue of process entries kept in ascending key order in a row of cells.
// ----------------------------------------------------------------------------
// One transaction is handled at a time. On dequeue and peek, once the output
// is free, the front cell is read and, for a dequeue, the row shifts up by one
// in the same cycle. On enqueue the new entry travels down the cell row one
// cell per cycle as an insertion wave, and the wave ends at the cell just past
// the last held entry. Enqueue on a full queue and the unused command skip it.
// cfg_data selects the key (0 CPU time, 1 arrival time) and is to be written
// only while the queue is idle by the user; the block does not enforce this.
module sorted_priority_queue #(
    parameter int QUEUE_DEPTH = 64,
    parameter int TIME_BITS   = 16,
    localparam int CNT_W      = $clog2(QUEUE_DEPTH + 1)
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic                          cfg_data,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [1:0]                    s_command,
    input  logic [spq_pkg::TAG_BITS-1:0]  s_process_tag,
    input  logic [TIME_BITS-1:0]          s_cpu_time,
    input  logic [TIME_BITS-1:0]          s_arrival_time,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic                          m_ok,
    output logic [spq_pkg::TAG_BITS-1:0]  m_front_tag,
    output logic [TIME_BITS-1:0]          m_front_cpu_time,
    output logic [TIME_BITS-1:0]          m_front_arrival_time,
    output logic [CNT_W-1:0]              m_entry_count
);
    import spq_pkg::*;

    localparam int ENT_W = TAG_BITS + 2 * TIME_BITS;

    state_t           state_reg, state_next;
    cmd_t             cmd_reg, cmd_next;
    logic             enq_ok_reg, enq_ok_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [CNT_W-1:0] wave_cnt_reg, wave_cnt_next;
    logic             mode_reg;
    logic             link0_valid_reg, link0_valid_next;
    logic [ENT_W-1:0] link0_entry_reg, link0_entry_next;

    logic                 m_valid_reg, m_valid_next;
    logic                 ok_reg, ok_next;
    logic [TAG_BITS-1:0]  tag_reg, tag_next;
    logic [TIME_BITS-1:0] ct_reg, ct_next;
    logic [TIME_BITS-1:0] at_reg, at_next;
    logic [CNT_W-1:0]     cnt_out_reg, cnt_out_next;

    cell_ctrl_t       ctrl;
    logic             out_free;
    logic             s_fire;
    cmd_t             s_cmd;

    logic             link_valid  [QUEUE_DEPTH];
    logic             link_placed [QUEUE_DEPTH];
    logic [ENT_W-1:0] link_entry  [QUEUE_DEPTH];
    logic [ENT_W-1:0] ent         [QUEUE_DEPTH];

    assign cfg_ready = 1'b1;
    assign s_ready   = (state_reg == ST_IDLE);
    assign s_fire    = s_valid && s_ready;
    assign s_cmd     = cmd_t'(s_command);
    assign out_free  = !m_valid_reg || m_ready;

    assign link_valid[0]  = link0_valid_reg;
    assign link_placed[0] = 1'b0;
    assign link_entry[0]  = link0_entry_reg;

    always_comb begin
        state_next       = state_reg;
        cmd_next         = cmd_reg;
        enq_ok_next      = enq_ok_reg;
        count_next       = count_reg;
        wave_cnt_next    = wave_cnt_reg;
        link0_valid_next = 1'b0;
        link0_entry_next = link0_entry_reg;
        m_valid_next     = m_valid_reg && !m_ready;
        ok_next          = ok_reg;
        tag_next         = tag_reg;
        ct_next          = ct_reg;
        at_next          = at_reg;
        cnt_out_next     = cnt_out_reg;
        ctrl.shift       = 1'b0;
        ctrl.order_mode  = mode_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_fire) begin
                    cmd_next    = s_cmd;
                    enq_ok_next = count_reg < CNT_W'(QUEUE_DEPTH);
                    if (s_cmd == CMD_ENQUEUE && count_reg < CNT_W'(QUEUE_DEPTH)) begin
                        link0_valid_next = 1'b1;
                        link0_entry_next = {s_process_tag, s_cpu_time, s_arrival_time};
                        wave_cnt_next    = '0;
                        state_next       = ST_WAVE;
                    end else begin
                        state_next = ST_POST;
                    end
                end
            end
            ST_WAVE: begin
                // Cell wave_cnt_reg handles the wave this cycle
                wave_cnt_next = wave_cnt_reg + CNT_W'(1);
                if (wave_cnt_reg == count_reg) begin
                    count_next = count_reg + CNT_W'(1);
                    state_next = ST_POST;
                end
            end
            ST_POST: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    ok_next      = 1'b0;
                    tag_next     = '0;
                    ct_next      = '0;
                    at_next      = '0;
                    cnt_out_next = count_reg;
                    state_next   = ST_IDLE;
                    case (cmd_reg)
                        CMD_ENQUEUE: begin
                            ok_next = enq_ok_reg;
                        end
                        CMD_DEQUEUE, CMD_PEEK: begin
                            if (count_reg != '0) begin
                                ok_next  = 1'b1;
                                tag_next = ent[0][ENT_W-1 -: TAG_BITS];
                                ct_next  = ent[0][2*TIME_BITS-1 -: TIME_BITS];
                                at_next  = ent[0][TIME_BITS-1:0];
                                if (cmd_reg == CMD_DEQUEUE) begin
                                    ctrl.shift   = 1'b1;
                                    count_next   = count_reg - CNT_W'(1);
                                    cnt_out_next = count_reg - CNT_W'(1);
                                end
                            end
                        end
                        default: begin
                            ok_next = 1'b0;
                        end
                    endcase
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= ST_IDLE;
            count_reg       <= '0;
            mode_reg        <= KEY_CPU;
            link0_valid_reg <= 1'b0;
            m_valid_reg     <= 1'b0;
        end else begin
            state_reg       <= state_next;
            count_reg       <= count_next;
            link0_valid_reg <= link0_valid_next;
            m_valid_reg     <= m_valid_next;
            if (cfg_valid && cfg_ready) begin
                mode_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        cmd_reg         <= cmd_next;
        enq_ok_reg      <= enq_ok_next;
        wave_cnt_reg    <= wave_cnt_next;
        link0_entry_reg <= link0_entry_next;
        ok_reg          <= ok_next;
        tag_reg         <= tag_next;
        ct_reg          <= ct_next;
        at_reg          <= at_next;
        cnt_out_reg     <= cnt_out_next;
    end

    generate
        for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
            if (i < QUEUE_DEPTH - 1) begin : g_mid
                spq_cell #(
                    .INDEX    (i),
                    .TIME_BITS(TIME_BITS),
                    .CNT_W    (CNT_W)
                ) u_cell (
                    .aclk         (aclk),
                    .aresetn      (aresetn),
                    .ctrl         (ctrl),
                    .count        (count_reg),
                    .pass_valid_i (link_valid[i]),
                    .pass_placed_i(link_placed[i]),
                    .pass_entry_i (link_entry[i]),
                    .shift_entry_i(ent[i+1]),
                    .entry_o      (ent[i]),
                    .pass_valid_o (link_valid[i+1]),
                    .pass_placed_o(link_placed[i+1]),
                    .pass_entry_o (link_entry[i+1])
                );
            end else begin : g_last
                // Last slot only ever ends a wave; its pass stage stays unused
                spq_cell #(
                    .INDEX    (i),
                    .TIME_BITS(TIME_BITS),
                    .CNT_W    (CNT_W)
                ) u_cell (
                    .aclk         (aclk),
                    .aresetn      (aresetn),
                    .ctrl         (ctrl),
                    .count        (count_reg),
                    .pass_valid_i (link_valid[i]),
                    .pass_placed_i(link_placed[i]),
                    .pass_entry_i (link_entry[i]),
                    .shift_entry_i(ent[i]),
                    .entry_o      (ent[i]),
                    .pass_valid_o (),
                    .pass_placed_o(),
                    .pass_entry_o ()
                );
            end
        end
    endgenerate

    assign m_valid              = m_valid_reg;
    assign m_ok                 = ok_reg;
    assign m_front_tag          = tag_reg;
    assign m_front_cpu_time     = ct_reg;
    assign m_front_arrival_time = at_reg;
    assign m_entry_count        = cnt_out_reg;

endmodule

// File: hw/rtl/spq_checker.sv
// ----------------------------------------------------------------------------
// spq_checker
// Port-level checks for the sorted priority queue, bound to the top level.
// ----------------------------------------------------------------------------
module spq_checker #(
    parameter int QUEUE_DEPTH = 64,
    parameter int TIME_BITS   = 16,
    localparam int CNT_W      = $clog2(QUEUE_DEPTH + 1)
) (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          s_valid,
    input logic                          s_ready,
    input logic                          m_valid,
    input logic                          m_ready,
    input logic                          m_ok,
    input logic [spq_pkg::TAG_BITS-1:0]  m_front_tag,
    input logic [TIME_BITS-1:0]          m_front_cpu_time,
    input logic [TIME_BITS-1:0]          m_front_arrival_time,
    input logic [CNT_W-1:0]              m_entry_count
);
    import spq_pkg::*;

    // A stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_ok) && $stable(m_front_tag)
            && $stable(m_front_cpu_time) && $stable(m_front_arrival_time)
            && $stable(m_entry_count))
        else $error("result changed while stalled");

    // One transaction in flight: busy right after an accept
    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("input accepted while busy");

    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_entry_count <= CNT_W'(QUEUE_DEPTH))
        else $error("entry count above depth");

    a_fail_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ok |-> m_front_tag == '0 && m_front_cpu_time == '0
            && m_front_arrival_time == '0)
        else $error("failed result carries front data");

endmodule

bind sorted_priority_queue spq_checker #(
    .QUEUE_DEPTH(QUEUE_DEPTH),
    .TIME_BITS  (TIME_BITS)
) u_spq_checker (.*);
